// File: hdl/fmqd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fmqd_pkg;

	// cordic depth and angle table, angles at 2^24 per pi
	localparam int CORDIC_STAGES = 16;
	localparam int ANG_LEN       = 24;
	localparam int NSTAGES       = (CORDIC_STAGES < ANG_LEN) ? CORDIC_STAGES : ANG_LEN;
	localparam int STAGE_W       = $clog2(NSTAGES);
	localparam int ANG_IDX_W     = $clog2(ANG_LEN);

	localparam int ANG_TABLE [ANG_LEN] = '{
		4194304, 2476042, 1308273, 664100, 333339, 166832, 83436, 41721,
		20861, 10430, 5215, 2608, 1304, 652, 326, 163,
		81, 41, 20, 10, 5, 3, 1, 1
	};

	localparam int HALF_PI_ANG = 8388608;

	// datapath widths: x grows by the cordic gain over a 33 bit product
	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int XY_W     = 36;
	localparam int Z_W      = 27;

	// output scaling
	localparam int AUDIO_LIMIT = 24576;
	localparam int ALPHA_ONE   = 65536;
	localparam int GAIN_W      = 16;
	localparam int ALPHA_W     = 17;

	// register reset values
	localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd6554;
	localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62063;

	// configuration register map
	typedef enum logic [0:0] {
		REG_GAIN  = 1'b0,
		REG_ALPHA = 1'b1
	} cfg_reg_t;

	localparam int CFG_DATA_W = ALPHA_W;

	// one request travelling down the cordic chain
	typedef struct packed {
		logic                   valid;
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   xy_zero;
		logic                   in_zero;
		logic                   blk_end;
	} cordic_t;

endpackage

`default_nettype wire

// File: hdl/fmqd_if.sv
`timescale 1ns / 1ps
`default_nettype none

// iq sample channel
interface fmqd_iq_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] i_sample;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] q_sample;
	logic                                 block_end;

	modport source (output valid, output i_sample, output q_sample, output block_end,
		input ready);
	modport sink (input valid, input i_sample, input q_sample, input block_end,
		output ready);
endinterface

// audio sample channel
interface fmqd_audio_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] audio_sample;
	logic                                 block_end_out;

	modport source (output valid, output audio_sample, output block_end_out, input ready);
	modport sink (input valid, input audio_sample, input block_end_out, output ready);
endinterface

// register write channel
interface fmqd_cfg_if;
	logic                                valid;
	logic                                ready;
	fmqd_pkg::cfg_reg_t                  reg_index;
	logic [fmqd_pkg::CFG_DATA_W-1:0]     wr_data;

	modport source (output valid, output reg_index, output wr_data, input ready);
	modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

`default_nettype wire

// File: hdl/fmqd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module fmqd_front (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 accept,
	input  wire logic signed [fmqd_pkg::SAMPLE_W-1:0] i_sample,
	input  wire logic signed [fmqd_pkg::SAMPLE_W-1:0] q_sample,
	input  wire logic                                 block_end,
	output fmqd_pkg::cordic_t                         head
);

	logic signed [fmqd_pkg::SAMPLE_W-1:0] prev_i_q;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] prev_q_q;

	logic                               valid_s1;
	logic                               in_zero_s1;
	logic                               blk_end_s1;
	logic signed [fmqd_pkg::PROD_W-1:0] p_ii_s1;
	logic signed [fmqd_pkg::PROD_W-1:0] p_qq_s1;
	logic signed [fmqd_pkg::PROD_W-1:0] p_qi_s1;
	logic signed [fmqd_pkg::PROD_W-1:0] p_iq_s1;

	logic signed [fmqd_pkg::XY_W-1:0] re_w;
	logic signed [fmqd_pkg::XY_W-1:0] im_w;
	logic signed [fmqd_pkg::XY_W-1:0] x_w;
	logic signed [fmqd_pkg::XY_W-1:0] y_w;
	logic signed [fmqd_pkg::Z_W-1:0]  z_w;

	// previous sample, replaced by every accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q <= '0;
			prev_q_q <= '0;
		end else if (accept) begin
			prev_i_q <= i_sample;
			prev_q_q <= q_sample;
		end
	end

	// stage 1: partial products of sample times conjugate of previous
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_ii_s1    <= i_sample * prev_i_q;
			p_qq_s1    <= q_sample * prev_q_q;
			p_qi_s1    <= q_sample * prev_i_q;
			p_iq_s1    <= i_sample * prev_q_q;
			in_zero_s1 <= (i_sample == '0) && (q_sample == '0);
			blk_end_s1 <= block_end;
		end
	end

	// stage 2: sum products and pre-rotate into the right half plane
	always_comb begin
		re_w = fmqd_pkg::XY_W'(p_ii_s1) + fmqd_pkg::XY_W'(p_qq_s1);
		im_w = fmqd_pkg::XY_W'(p_qi_s1) - fmqd_pkg::XY_W'(p_iq_s1);
		x_w  = re_w;
		y_w  = im_w;
		z_w  = '0;
		if (re_w[fmqd_pkg::XY_W-1]) begin
			if (!im_w[fmqd_pkg::XY_W-1]) begin
				x_w = im_w;
				y_w = -re_w;
				z_w = fmqd_pkg::Z_W'(fmqd_pkg::HALF_PI_ANG);
			end else begin
				x_w = -im_w;
				y_w = re_w;
				z_w = -fmqd_pkg::Z_W'(fmqd_pkg::HALF_PI_ANG);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head <= '0;
		end else begin
			head.valid <= valid_s1;
			if (valid_s1) begin
				head.x       <= x_w;
				head.y       <= y_w;
				head.z       <= z_w;
				head.xy_zero <= (re_w == '0) && (im_w == '0);
				head.in_zero <= in_zero_s1;
				head.blk_end <= blk_end_s1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/fmqd_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module fmqd_cordic_cell (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [fmqd_pkg::STAGE_W-1:0] stage,
	input  wire fmqd_pkg::cordic_t            cin,
	output fmqd_pkg::cordic_t                 cout
);

	logic signed [fmqd_pkg::XY_W-1:0] xs_w;
	logic signed [fmqd_pkg::XY_W-1:0] ys_w;
	logic signed [fmqd_pkg::Z_W-1:0]  ang_w;

	// shifted neighbors and the micro-rotation angle of this cell
	assign xs_w  = cin.x >>> stage;
	assign ys_w  = cin.y >>> stage;
	assign ang_w = fmqd_pkg::Z_W'(fmqd_pkg::ANG_TABLE[fmqd_pkg::ANG_IDX_W'(stage)]);

	// rotate toward the x axis, direction from the sign of y
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cout <= '0;
		end else begin
			cout.valid <= cin.valid;
			if (!cin.y[fmqd_pkg::XY_W-1]) begin
				cout.x <= cin.x + ys_w;
				cout.y <= cin.y - xs_w;
				cout.z <= cin.z + ang_w;
			end else begin
				cout.x <= cin.x - ys_w;
				cout.y <= cin.y + xs_w;
				cout.z <= cin.z - ang_w;
			end
			cout.xy_zero <= cin.xy_zero;
			cout.in_zero <= cin.in_zero;
			cout.blk_end <= cin.blk_end;
		end
	end

endmodule

`default_nettype wire

// File: hdl/fmqd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module fmqd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire fmqd_pkg::cordic_t              tail,
	input  wire logic [fmqd_pkg::GAIN_W-1:0]    gain,
	input  wire logic [fmqd_pkg::ALPHA_W-1:0]   alpha,
	output logic                                done,
	fmqd_audio_if.source                        out
);

	localparam int GP_W  = fmqd_pkg::SAMPLE_W + fmqd_pkg::GAIN_W + 1;
	localparam int MUL_W = fmqd_pkg::ALPHA_W + 1 + fmqd_pkg::SAMPLE_W;
	localparam int SUM_W = MUL_W + 1;

	logic signed [fmqd_pkg::Z_W-1:0]      zr_w;
	logic signed [fmqd_pkg::Z_W-1:0]      zsh_w;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] phase_w;

	logic                                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                                 in_zero_s1, in_zero_s2, in_zero_s3, in_zero_s4;
	logic                                 blk_end_s1, blk_end_s2, blk_end_s3, blk_end_s4;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] ph_s1;
	logic signed [GP_W-1:0]               gp_s2;
	logic signed [GP_W-1:0]               gr_w;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] demod_w;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] demod_s3;
	logic [fmqd_pkg::ALPHA_W-1:0]         a_sat_w;
	logic [fmqd_pkg::ALPHA_W-1:0]         oma_w;
	logic signed [MUL_W-1:0]              m1_s4;
	logic signed [MUL_W-1:0]              m2_s4;
	logic signed [SUM_W-1:0]              sum_w;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] audio_w;
	logic signed [fmqd_pkg::SAMPLE_W-1:0] deemph_q;
	logic                                 move;

	// stage 1: round angle to q1.15 units of pi and saturate, zero for a zero product
	always_comb begin
		zr_w  = tail.z + fmqd_pkg::Z_W'(256);
		zsh_w = zr_w >>> 9;
		if (zsh_w > fmqd_pkg::Z_W'(32767)) begin
			phase_w = 16'sh7fff;
		end else if (zsh_w < -fmqd_pkg::Z_W'(32768)) begin
			phase_w = -16'sh8000;
		end else begin
			phase_w = zsh_w[fmqd_pkg::SAMPLE_W-1:0];
		end
		if (tail.xy_zero) begin
			phase_w = '0;
		end
	end

	// stage 3: round and clamp the scaled phase
	always_comb begin
		gr_w = (gp_s2 + GP_W'(4096)) >>> 13;
		if (gr_w > GP_W'(fmqd_pkg::AUDIO_LIMIT)) begin
			demod_w = fmqd_pkg::SAMPLE_W'(fmqd_pkg::AUDIO_LIMIT);
		end else if (gr_w < -GP_W'(fmqd_pkg::AUDIO_LIMIT)) begin
			demod_w = -fmqd_pkg::SAMPLE_W'(fmqd_pkg::AUDIO_LIMIT);
		end else begin
			demod_w = gr_w[fmqd_pkg::SAMPLE_W-1:0];
		end
	end

	// de-emphasis coefficients, alpha saturated at one
	always_comb begin
		a_sat_w = (alpha > fmqd_pkg::ALPHA_W'(fmqd_pkg::ALPHA_ONE)) ?
			fmqd_pkg::ALPHA_W'(fmqd_pkg::ALPHA_ONE) : alpha;
		oma_w   = fmqd_pkg::ALPHA_W'(fmqd_pkg::ALPHA_ONE) - a_sat_w;
	end

	// stage 5: round the filter sum, clamp, zero on an all-zero sample
	always_comb begin
		sum_w = (SUM_W'(m1_s4) + SUM_W'(m2_s4) + SUM_W'(32768)) >>> 16;
		if (sum_w > SUM_W'(fmqd_pkg::AUDIO_LIMIT)) begin
			audio_w = fmqd_pkg::SAMPLE_W'(fmqd_pkg::AUDIO_LIMIT);
		end else if (sum_w < -SUM_W'(fmqd_pkg::AUDIO_LIMIT)) begin
			audio_w = -fmqd_pkg::SAMPLE_W'(fmqd_pkg::AUDIO_LIMIT);
		end else begin
			audio_w = sum_w[fmqd_pkg::SAMPLE_W-1:0];
		end
		if (in_zero_s4) begin
			audio_w = '0;
		end
	end

	// stage 4 hands over when the output register is free
	assign move = valid_s4 && (!out.valid || out.ready);
	assign done = move;

	// stage valids, stage 4 holds its request until it moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= tail.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3 || (valid_s4 && !move);
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (tail.valid) begin
			ph_s1      <= phase_w;
			in_zero_s1 <= tail.in_zero;
			blk_end_s1 <= tail.blk_end;
		end
		if (valid_s1) begin
			gp_s2      <= ph_s1 * $signed({1'b0, gain});
			in_zero_s2 <= in_zero_s1;
			blk_end_s2 <= blk_end_s1;
		end
		if (valid_s2) begin
			demod_s3   <= demod_w;
			in_zero_s3 <= in_zero_s2;
			blk_end_s3 <= blk_end_s2;
		end
		if (valid_s3) begin
			m1_s4      <= $signed({1'b0, oma_w}) * demod_s3;
			m2_s4      <= $signed({1'b0, a_sat_w}) * deemph_q;
			in_zero_s4 <= in_zero_s3;
			blk_end_s4 <= blk_end_s3;
		end
	end

	// filter state, untouched by an all-zero sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deemph_q <= '0;
		end else if (move && !in_zero_s4) begin
			deemph_q <= audio_w;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out.valid <= 1'b0;
		end else if (move) begin
			out.valid <= 1'b1;
		end else if (out.ready) begin
			out.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out.audio_sample  <= audio_w;
			out.block_end_out <= blk_end_s4;
		end
	end

endmodule

`default_nettype wire

// File: hdl/fm_quadrature_discriminator.sv
// FM quadrature discriminator with de-emphasis. Each iq request is multiplied
// by the conjugate of the previous sample, its phase is found by a chain of
// NSTAGES vectoring cells (CORDIC_STAGES, at most ANG_LEN), scaled by
// discriminator_gain (q4.12), clamped to +/-1.5 and passed through a
// first-order de-emphasis filter set by deemph_alpha (q1.16, values above
// 65536 act as 65536), giving one q2.14 audio request per iq request. An
// all-zero sample gives audio 0 and leaves the filter state alone. One request
// is in flight at a time: the next iq request is taken only after the audio
// request of the last one has reached the output register. The path runs
// through two front stages, the cordic cell chain and four back stages. A
// finished audio request may wait in the output register while the next iq
// request is being worked on. Registers are written through the cfg channel;
// write them only while the block is idle, the block itself does not enforce
// it.
`timescale 1ns / 1ps
`default_nettype none

module fm_quadrature_discriminator (
	input  wire logic    clk,
	input  wire logic    arst_n,
	fmqd_iq_if.sink      iq,
	fmqd_audio_if.source audio,
	fmqd_cfg_if.sink     cfg
);

	logic [fmqd_pkg::GAIN_W-1:0]  gain_q;
	logic [fmqd_pkg::ALPHA_W-1:0] alpha_q;
	logic                         busy_q;
	logic                         accept;
	logic                         done;

	fmqd_pkg::cordic_t chain [fmqd_pkg::NSTAGES+1];

	// configuration registers, always ready
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= fmqd_pkg::GAIN_RESET;
			alpha_q <= fmqd_pkg::ALPHA_RESET;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				fmqd_pkg::REG_GAIN: begin
					gain_q <= cfg.wr_data[fmqd_pkg::GAIN_W-1:0];
				end
				fmqd_pkg::REG_ALPHA: begin
					alpha_q <= cfg.wr_data;
				end
				default: begin
				end
			endcase
		end
	end

	// one request in flight until its result reaches the output register
	assign iq.ready = !busy_q;
	assign accept   = iq.valid && !busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// conjugate product and pre-rotation
	fmqd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.i_sample  (iq.i_sample),
		.q_sample  (iq.q_sample),
		.block_end (iq.block_end),
		.head      (chain[0])
	);

	// cordic cell chain
	for (genvar k = 0; k < fmqd_pkg::NSTAGES; k++) begin : g_cell
		fmqd_cordic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.stage  (fmqd_pkg::STAGE_W'(k)),
			.cin    (chain[k]),
			.cout   (chain[k+1])
		);
	end

	// scaling, de-emphasis and output register
	fmqd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.tail   (chain[fmqd_pkg::NSTAGES]),
		.gain   (gain_q),
		.alpha  (alpha_q),
		.done   (done),
		.out    (audio)
	);

endmodule

`default_nettype wire

// File: hdl/fmqd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module fmqd_assertions (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 iq_valid,
	input wire logic                                 iq_ready,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic signed [fmqd_pkg::SAMPLE_W-1:0] audio_sample
);

	logic [1:0] pend_q;
	logic       in_acc;
	logic       out_acc;

	assign in_acc  = iq_valid && iq_ready;
	assign out_acc = out_valid && out_ready;

	// requests taken in but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(in_acc) - 2'(out_acc);
		end
	end

	// no new iq request right after one is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !iq_ready)
		else $error("iq request taken while another is in flight");

	// audio stays within +/-1.5
	a_audio_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (audio_sample <= 16'sd24576) && (audio_sample >= -16'sd24576))
		else $error("audio sample out of range");

	// no audio request without a pending iq request
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("audio request without iq request");

	// at most one request in work plus one waiting
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many requests outstanding");

	// a stalled audio request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_sample))
		else $error("stalled audio request changed");

endmodule

bind fm_quadrature_discriminator fmqd_assertions u_fmqd_assertions (
	.clk          (clk),
	.arst_n       (arst_n),
	.iq_valid     (iq.valid),
	.iq_ready     (iq.ready),
	.out_valid    (audio.valid),
	.out_ready    (audio.ready),
	.audio_sample (audio.audio_sample)
);

`default_nettype wire
